// ----- src/gsbd_pkg.sv -----
// Shared types, constants and the CORDIC angle table of the Goertzel detector.
package gsbd_pkg;

   localparam int SAMPLE_BITS     = 16;
   localparam int COEFF_FRAC_BITS = 16;
   localparam int MAX_FRAME_LEN   = 4096;
   localparam int LEN_BITS        = 13;
   localparam int RES_BITS        = 48;
   localparam int COEFF_BITS      = 19;
   localparam int TW_BITS         = 18;
   localparam int VEC_BITS        = 50;
   localparam int ABS_BITS        = 49;
   localparam int MAG_BITS        = 40;
   localparam int PHASE_BITS      = 16;
   localparam int CORDIC_STEPS    = 20;
   localparam int CORDIC_BITS     = 53;
   localparam int Z_BITS          = 29;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 19;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_LENGTH    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RESONATOR_COEFF = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TWIDDLE_COSINE  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TWIDDLE_SINE    = 2'd3;

   localparam logic signed [Z_BITS-1:0] HALF_PI_Q24 = 29'sd26353589;
   localparam logic signed [17:0]       PHASE_LIM   = 18'sd25736;

   typedef struct packed {
      logic signed [VEC_BITS-1:0] re;
      logic signed [VEC_BITS-1:0] im;
   } gsbd_vec_type;

   // arctan(2^-i) in Q.24 radians
   function automatic logic signed [Z_BITS-1:0] atan_q24(input logic [4:0] i);
      logic signed [Z_BITS-1:0] a;
      unique case (i)
         5'd0:  a = 29'sd13176795;
         5'd1:  a = 29'sd7778716;
         5'd2:  a = 29'sd4110060;
         5'd3:  a = 29'sd2086331;
         5'd4:  a = 29'sd1047214;
         5'd5:  a = 29'sd524117;
         5'd6:  a = 29'sd262123;
         5'd7:  a = 29'sd131069;
         5'd8:  a = 29'sd65536;
         5'd9:  a = 29'sd32768;
         5'd10: a = 29'sd16384;
         5'd11: a = 29'sd8192;
         5'd12: a = 29'sd4096;
         5'd13: a = 29'sd2048;
         5'd14: a = 29'sd1024;
         5'd15: a = 29'sd512;
         5'd16: a = 29'sd256;
         5'd17: a = 29'sd128;
         5'd18: a = 29'sd64;
         5'd19: a = 29'sd32;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ----- src/gsbd_front.sv -----
// Front end: per-sample resonator update and frame-end twiddle products.
module gsbd_front (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      smp_valid,
   output logic                                      smp_ready,
   input  logic signed [gsbd_pkg::SAMPLE_BITS-1:0]   smp_value,
   input  logic [gsbd_pkg::LEN_BITS-1:0]             frame_length,
   input  logic signed [gsbd_pkg::COEFF_BITS-1:0]    resonator_coeff,
   input  logic signed [gsbd_pkg::TW_BITS-1:0]       twiddle_cosine,
   input  logic signed [gsbd_pkg::TW_BITS-1:0]       twiddle_sine,
   output logic                                      vec_valid,
   input  logic                                      vec_ready,
   output gsbd_pkg::gsbd_vec_type                    vec
);
   import gsbd_pkg::*;

   typedef enum logic [4:0] {
      F_IDLE = 5'b00001,
      F_MLO  = 5'b00010,
      F_MHI  = 5'b00100,
      F_FIN  = 5'b01000,
      F_PUSH = 5'b10000
   } front_state_type;

   typedef enum logic [1:0] {
      OP_RES = 2'd0,
      OP_COS = 2'd1,
      OP_SIN = 2'd2
   } front_op_type;

   front_state_type state_ff, state_in;
   front_op_type    op_ff, op_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [COEFF_BITS-1:0]  mcoef_ff, mcoef_in;
   logic signed [RES_BITS-1:0]    mopnd_ff, mopnd_in;
   logic signed [67:0]            acc_ff, acc_in;
   logic signed [RES_BITS-1:0]    s1_ff, s1_in, s2_ff, s2_in;
   logic [LEN_BITS-1:0]           idx_ff, idx_in;
   logic signed [VEC_BITS-1:0]    re_ff, re_in, im_ff, im_in;

   logic signed [24:0]            mul_b;
   logic signed [43:0]            prod;
   logic signed [51:0]            scaled;
   logic signed [53:0]            sum;
   logic signed [RES_BITS-1:0]    sat;
   logic [LEN_BITS-1:0]           len_eff;
   logic [LEN_BITS-1:0]           idx_next;

   // 19 x 25 partial product: low 24 bits unsigned, then high 24 bits signed
   assign mul_b = (state_ff == F_MLO) ? $signed({1'b0, mopnd_ff[23:0]})
                                      : $signed({mopnd_ff[47], mopnd_ff[47:24]});
   assign prod   = mcoef_ff * mul_b;
   assign scaled = acc_ff[67:16];

   assign sum = $signed({{22{sample_ff[SAMPLE_BITS-1]}}, sample_ff, 16'b0})
              + $signed({{2{scaled[51]}}, scaled})
              - $signed({{6{s2_ff[RES_BITS-1]}}, s2_ff});

   always_comb begin
      if (sum[53:47] != {7{sum[53]}}) begin
         sat = sum[53] ? {1'b1, {(RES_BITS-1){1'b0}}} : {1'b0, {(RES_BITS-1){1'b1}}};
      end else begin
         sat = sum[RES_BITS-1:0];
      end
   end

   always_comb begin
      if (frame_length == '0) begin
         len_eff = LEN_BITS'(1);
      end else if (frame_length > LEN_BITS'(MAX_FRAME_LEN)) begin
         len_eff = LEN_BITS'(MAX_FRAME_LEN);
      end else begin
         len_eff = frame_length;
      end
   end

   assign idx_next = idx_ff + LEN_BITS'(1);

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      sample_in = sample_ff;
      mcoef_in  = mcoef_ff;
      mopnd_in  = mopnd_ff;
      acc_in    = acc_ff;
      s1_in     = s1_ff;
      s2_in     = s2_ff;
      idx_in    = idx_ff;
      re_in     = re_ff;
      im_in     = im_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (smp_valid) begin
               sample_in = smp_value;
               mcoef_in  = resonator_coeff;
               mopnd_in  = s1_ff;
               op_in     = OP_RES;
               state_in  = F_MLO;
            end
         end
         F_MLO: begin
            acc_in   = 68'(prod);
            state_in = F_MHI;
         end
         F_MHI: begin
            acc_in   = acc_ff + $signed({prod, 24'b0});
            state_in = F_FIN;
         end
         F_FIN: begin
            unique case (op_ff)
               OP_RES: begin
                  s1_in = sat;
                  s2_in = s1_ff;
                  if (idx_next >= len_eff) begin
                     idx_in   = '0;
                     op_in    = OP_COS;
                     mcoef_in = COEFF_BITS'(twiddle_cosine);
                     mopnd_in = s1_ff;
                     state_in = F_MLO;
                  end else begin
                     idx_in   = idx_next;
                     state_in = F_IDLE;
                  end
               end
               OP_COS: begin
                  re_in    = VEC_BITS'(s1_ff) - scaled[VEC_BITS-1:0];
                  op_in    = OP_SIN;
                  mcoef_in = COEFF_BITS'(twiddle_sine);
                  state_in = F_MLO;
               end
               OP_SIN: begin
                  im_in    = scaled[VEC_BITS-1:0];
                  state_in = F_PUSH;
               end
               default: state_in = F_IDLE;
            endcase
         end
         F_PUSH: begin
            if (vec_ready) begin
               s1_in    = '0;
               s2_in    = '0;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         op_ff    <= OP_RES;
         s1_ff    <= '0;
         s2_ff    <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      mcoef_ff  <= mcoef_in;
      mopnd_ff  <= mopnd_in;
      acc_ff    <= acc_in;
      re_ff     <= re_in;
      im_ff     <= im_in;
   end

   assign smp_ready = (state_ff == F_IDLE);
   assign vec_valid = (state_ff == F_PUSH);
   assign vec.re    = re_ff;
   assign vec.im    = im_ff;

endmodule

// ----- src/gsbd_queue.sv -----
// Two-entry queue carrying frame-end vectors from front to back.
module gsbd_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  gsbd_pkg::gsbd_vec_type in_vec,
   output logic                   out_valid,
   input  logic                   out_ready,
   output gsbd_pkg::gsbd_vec_type out_vec
);
   import gsbd_pkg::*;

   gsbd_vec_type mem [2];
   logic         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_vec   = mem[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= in_vec;
      end
   end

endmodule

// ----- src/gsbd_back.sv -----
// Back end: squared norm, digit-serial square root and CORDIC phase.
module gsbd_back (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     vec_valid,
   output logic                                     vec_ready,
   input  gsbd_pkg::gsbd_vec_type                   vec,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output logic [gsbd_pkg::MAG_BITS-1:0]            out_mag,
   output logic signed [gsbd_pkg::PHASE_BITS-1:0]   out_phase
);
   import gsbd_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_SQ   = 4'b0010,
      B_ROOT = 4'b0100,
      B_DONE = 4'b1000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [5:0]                    cnt_ff, cnt_in;
   logic [ABS_BITS-1:0]           abs_re_ff, abs_re_in, abs_im_ff, abs_im_in;
   logic [99:0]                   rad_ff, rad_in;
   logic [52:0]                   rem_ff, rem_in;
   logic [49:0]                   root_ff, root_in;
   logic signed [CORDIC_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [Z_BITS-1:0]      z_ff, z_in;
   logic                          zero_ff, zero_in;
   logic                          ovalid_ff, ovalid_in;
   logic [MAG_BITS-1:0]           mag_ff, mag_in;
   logic signed [PHASE_BITS-1:0]  phase_ff, phase_in;

   logic [ABS_BITS-1:0]           sq_src;
   logic [24:0]                   op_a, op_b;
   logic [49:0]                   sq_prod;
   logic [99:0]                   sq_term;
   logic [52:0]                   rem_sh, trial;
   logic signed [CORDIC_BITS-1:0] dx, dy, re_x, im_x;
   logic [4:0]                    step;
   logic signed [Z_BITS-1:0]      ang, z_rnd;
   logic signed [17:0]            z_q13;
   logic signed [PHASE_BITS-1:0]  phase_val;

   // squares: four 25 x 25 partials per operand, re first then im
   assign sq_src = cnt_ff[2] ? abs_im_ff : abs_re_ff;
   assign op_a   = (cnt_ff[1:0] == 2'd3) ? {1'b0, sq_src[48:25]} : sq_src[24:0];
   assign op_b   = (cnt_ff[1:0] == 2'd0) ? sq_src[24:0] : {1'b0, sq_src[48:25]};
   assign sq_prod = op_a * op_b;

   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    sq_term = 100'(sq_prod);
         2'd1,
         2'd2:    sq_term = {25'b0, sq_prod, 25'b0};
         2'd3:    sq_term = {sq_prod, 50'b0};
         default: sq_term = '0;
      endcase
   end

   // restoring square root, two radicand bits per step
   assign rem_sh = {rem_ff[50:0], rad_ff[99:98]};
   assign trial  = {1'b0, root_ff, 2'b01};

   assign step = cnt_ff[4:0];
   assign dx   = y_ff >>> step;
   assign dy   = x_ff >>> step;
   assign ang  = atan_q24(step);
   assign re_x = CORDIC_BITS'(vec.re);
   assign im_x = CORDIC_BITS'(vec.im);

   assign z_rnd = z_ff + Z_BITS'(1024);
   assign z_q13 = z_rnd[28:11];

   always_comb begin
      if (zero_ff) begin
         phase_val = '0;
      end else if (z_q13 > PHASE_LIM) begin
         phase_val = PHASE_BITS'(PHASE_LIM);
      end else if (z_q13 < -PHASE_LIM) begin
         phase_val = PHASE_BITS'(-PHASE_LIM);
      end else begin
         phase_val = z_q13[PHASE_BITS-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      abs_re_in = abs_re_ff;
      abs_im_in = abs_im_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      zero_in   = zero_ff;
      ovalid_in = ovalid_ff;
      mag_in    = mag_ff;
      phase_in  = phase_ff;
      if (ovalid_ff && out_ready) begin
         ovalid_in = 1'b0;
      end
      unique case (state_ff)
         B_IDLE: begin
            if (vec_valid) begin
               abs_re_in = vec.re[VEC_BITS-1] ? ABS_BITS'(-vec.re) : ABS_BITS'(vec.re);
               abs_im_in = vec.im[VEC_BITS-1] ? ABS_BITS'(-vec.im) : ABS_BITS'(vec.im);
               zero_in   = (vec.re == '0) && (vec.im == '0);
               rad_in    = '0;
               rem_in    = '0;
               root_in   = '0;
               cnt_in    = '0;
               // quarter-turn pre-rotation into the right half plane
               if (vec.re[VEC_BITS-1]) begin
                  if (!vec.im[VEC_BITS-1]) begin
                     x_in = im_x;
                     y_in = -re_x;
                     z_in = HALF_PI_Q24;
                  end else begin
                     x_in = -im_x;
                     y_in = re_x;
                     z_in = -HALF_PI_Q24;
                  end
               end else begin
                  x_in = re_x;
                  y_in = im_x;
                  z_in = '0;
               end
               state_in = B_SQ;
            end
         end
         B_SQ: begin
            rad_in = rad_ff + sq_term;
            if (cnt_ff == 6'd7) begin
               cnt_in   = '0;
               state_in = B_ROOT;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         B_ROOT: begin
            rad_in = {rad_ff[97:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[48:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[48:0], 1'b0};
            end
            if (cnt_ff < 6'(CORDIC_STEPS)) begin
               if (!y_ff[CORDIC_BITS-1]) begin
                  x_in = x_ff + dx;
                  y_in = y_ff - dy;
                  z_in = z_ff + ang;
               end else begin
                  x_in = x_ff - dx;
                  y_in = y_ff + dy;
                  z_in = z_ff - ang;
               end
            end
            if (cnt_ff == 6'd49) begin
               state_in = B_DONE;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         B_DONE: begin
            if (!ovalid_ff || out_ready) begin
               ovalid_in = 1'b1;
               mag_in    = MAG_BITS'(root_ff[49:16]);
               phase_in  = phase_val;
               state_in  = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_IDLE;
         cnt_ff    <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      abs_re_ff <= abs_re_in;
      abs_im_ff <= abs_im_in;
      rad_ff    <= rad_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      zero_ff   <= zero_in;
      mag_ff    <= mag_in;
      phase_ff  <= phase_in;
   end

   assign vec_ready = (state_ff == B_IDLE);
   assign out_valid = ovalid_ff;
   assign out_mag   = mag_ff;
   assign out_phase = phase_ff;

endmodule

// ----- src/goertzel_single_bin_detector.sv -----
// Top level of the single-bin Goertzel detector.
//
// Usage:
//  req_*  : one signed 16-bit sample per item, tdata[15:0].
//  rsp_*  : one item per frame, tdata[39:0] magnitude, tdata[55:40] phase (Q3.13 rad).
//  csr_*  : register writes (0 frame length, 1 resonator coeff, 2 cosine,
//           3 sine), always ready; write only while the block is idle.
// In the front, each sample passes through two partial products of a
//  shared 19 x 25 multiplier, then the resonator update, and a new sample is
//  taken only back in idle; the last sample of a frame goes on to the cosine
//  and sine products and a push to the queue. The back forms the squares from
//  partial products, then runs 50 square-root steps with the 20 CORDIC steps alongside.
// A two-entry queue sits between front and back, and the back holds one
//  finished result in its output register, so a stalled receiver stops the
//  front only after the queue fills.
// Reset (synchronous) restores register defaults, clears the resonator, the
//  sample count, the queue and the output valid.
module goertzel_single_bin_detector (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [15:0]                            req_tdata,   // [15:0] sample_value
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [55:0]                            rsp_tdata,   // [39:0] bin_magnitude, [55:40] bin_phase
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [gsbd_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [gsbd_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import gsbd_pkg::*;

   logic [LEN_BITS-1:0]          frame_length_ff;
   logic signed [COEFF_BITS-1:0] coeff_ff;
   logic signed [TW_BITS-1:0]    cos_ff, sin_ff;

   gsbd_vec_type                 fr_vec, bk_vec;
   logic                         fr_valid, fr_ready, bk_valid, bk_ready;
   logic [MAG_BITS-1:0]          mag;
   logic signed [PHASE_BITS-1:0] phase;

   assign csr_ready = 1'b1;

   // configuration registers; unknown indexes cannot occur with 2 index bits
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= LEN_BITS'(256);
         coeff_ff        <= '0;
         cos_ff          <= TW_BITS'(65536);
         sin_ff          <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_LENGTH:    frame_length_ff <= csr_data[LEN_BITS-1:0];
            CSR_RESONATOR_COEFF: coeff_ff        <= csr_data[COEFF_BITS-1:0];
            CSR_TWIDDLE_COSINE:  cos_ff          <= csr_data[TW_BITS-1:0];
            CSR_TWIDDLE_SINE:    sin_ff          <= csr_data[TW_BITS-1:0];
            default: ;
         endcase
      end
   end

   gsbd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .smp_valid       (req_tvalid),
      .smp_ready       (req_tready),
      .smp_value       ($signed(req_tdata)),
      .frame_length    (frame_length_ff),
      .resonator_coeff (coeff_ff),
      .twiddle_cosine  (cos_ff),
      .twiddle_sine    (sin_ff),
      .vec_valid       (fr_valid),
      .vec_ready       (fr_ready),
      .vec             (fr_vec)
   );

   gsbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_vec    (fr_vec),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_vec   (bk_vec)
   );

   gsbd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .vec_valid (bk_valid),
      .vec_ready (bk_ready),
      .vec       (bk_vec),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_mag   (mag),
      .out_phase (phase)
   );

   assign rsp_tdata = {phase, mag};

endmodule

// ----- src/gsbd_checker.sv -----
// Port-level checks of the result channel, bound to the top level.
module gsbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_reset_idle: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[55:40]) <= 16'sd25736) &&
                     ($signed(rsp_tdata[55:40]) >= -16'sd25736))
      else $error("phase outside +/- pi");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39:34] == 6'd0))
      else $error("magnitude beyond reachable range");

endmodule

bind goertzel_single_bin_detector gsbd_checker u_gsbd_checker (.*);

// ----- tb/sv/tb.sv -----
// Self-checking bench for the single-bin Goertzel detector: bit-exact frame predictor.
`timescale 1ns / 1ps

module tb;
   import gsbd_pkg::*;

   typedef struct {
      logic [39:0]        mag;
      logic signed [15:0] ph;
   } bin_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // [15:0] sample_value
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // [39:0] bin_magnitude, [55:40] bin_phase
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_FRAME_LENGTH;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // samples waiting for the driver, frame results waiting for the DUT
   logic [15:0]    sample_queue[$];
   bin_result_type bin_results[$];
   bit             quiet = 1'b0;     // no idling on either side
   int             errors = 0;
   int             stuck = 0;

   // predictor copy of registers and resonator
   logic [12:0]        frame_len;
   logic signed [18:0] res_coeff;
   logic signed [17:0] tw_cos;
   logic signed [17:0] tw_sin;
   logic signed [47:0] res_last;
   logic signed [47:0] res_prev;
   int unsigned        taken;

   goertzel_single_bin_detector DUT (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // floor(c * s / 2^16)
   function automatic logic signed [79:0] qmul(logic signed [79:0] c, logic signed [79:0] s);
      logic signed [79:0] p;
      p = c * s;
      return p >>> COEFF_FRAC_BITS;
   endfunction

   function automatic logic [39:0] bin_mag(logic signed [79:0] re, logic signed [79:0] im);
      logic [127:0] a, b, y, r, c;
      a = re < 0 ? -re : re;
      b = im < 0 ? -im : im;
      y = a * a + b * b;
      r = '0;
      for (int k = 50; k >= 0; k--) begin
         c = r | (128'd1 << k);
         if (c * c <= y) r = c;
      end
      r = r >> 16;
      return r > 128'hFF_FFFF_FFFF ? 40'hFF_FFFF_FFFF : r[39:0];
   endfunction

   function automatic logic signed [15:0] bin_phase(longint re, longint im);
      longint atan_tab[20] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                               262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                               1024, 512, 256, 128, 64, 32};
      longint x, y, z, dx, dy;
      x = re;
      y = im;
      z = 0;
      if (re == 0 && im == 0) return '0;
      if (re < 0) begin
         // quarter-turn pre-rotation into the right half plane
         if (im >= 0) begin
            x = im; y = -re; z = 26353589;
         end else begin
            x = -im; y = re; z = -26353589;
         end
      end
      for (int i = 0; i < 20; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_tab[i];
         end else begin
            x -= dx; y += dy; z -= atan_tab[i];
         end
      end
      z = (z + 1024) >>> 11;
      if (z > 25736) z = 25736;
      if (z < -25736) z = -25736;
      return z[15:0];
   endfunction

   function automatic void goertzel_sample(logic signed [15:0] x);
      logic signed [79:0] s, re, im;
      int unsigned len;
      bin_result_type r;
      len = frame_len == 0 ? 1 : (frame_len > MAX_FRAME_LEN ? MAX_FRAME_LEN : frame_len);
      s = (80'(x) <<< 16) + qmul(res_coeff, res_last) - res_prev;
      if (s > 80'sh7FFF_FFFF_FFFF) s = 80'sh7FFF_FFFF_FFFF;
      if (s < -80'sh8000_0000_0000) s = -80'sh8000_0000_0000;
      res_prev = res_last;
      res_last = s[47:0];
      taken++;
      if (taken >= len) begin
         re = res_last - qmul(tw_cos, res_prev);
         im = qmul(tw_sin, res_prev);
         r.mag = bin_mag(re, im);
         r.ph  = bin_phase(64'(re), 64'(im));
         bin_results.push_back(r);
         res_last = '0;
         res_prev = '0;
         taken = 0;
      end
   endfunction

   // sample driver; the item in flight stays put until taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (sample_queue.size() != 0 && (quiet || $urandom_range(99) >= 25)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= sample_queue.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= quiet || $urandom_range(99) >= 25;
   end

   // monitor: predictor update on accepted items, result check, watchdog
   always @(posedge clock) begin
      bin_result_type want;
      if (reset) begin
         frame_len = 13'd256;
         res_coeff = '0;
         tw_cos    = 18'sd65536;
         tw_sin    = '0;
         res_last  = '0;
         res_prev  = '0;
         taken     = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_LENGTH:    frame_len = csr_data[12:0];
               CSR_RESONATOR_COEFF: res_coeff = csr_data;
               CSR_TWIDDLE_COSINE:  tw_cos    = csr_data[17:0];
               CSR_TWIDDLE_SINE:    tw_sin    = csr_data[17:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) goertzel_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (bin_results.size() == 0) begin
               $display("%0t: unexpected result, got mag %0d phase %0d", $realtime,
                        rsp_tdata[39:0], $signed(rsp_tdata[55:40]));
               errors++;
            end else begin
               want = bin_results.pop_front();
               if (rsp_tdata[39:0] !== want.mag) begin
                  $display("%0t: magnitude expected %0d got %0d", $realtime, want.mag,
                           rsp_tdata[39:0]);
                  errors++;
               end
               if (rsp_tdata[55:40] !== want.ph) begin
                  $display("%0t: phase expected %0d got %0d", $realtime, want.ph,
                           $signed(rsp_tdata[55:40]));
                  errors++;
               end
            end
         end
         // nothing moving on any channel for too long means a hang
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            stuck = 0;
         end else begin
            stuck++;
            if (stuck >= 6000) begin
               $display("tb: done, errors");
               $finish;
            end
         end
      end
   end

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_bin(int len, int coeff, int c, int s);
      csr_write(CSR_FRAME_LENGTH, len[18:0]);
      csr_write(CSR_RESONATOR_COEFF, coeff[18:0]);
      csr_write(CSR_TWIDDLE_COSINE, c[18:0]);
      csr_write(CSR_TWIDDLE_SINE, s[18:0]);
   endtask

   // block until every sample is in and every result out, then let the
   // front stage settle a partial frame
   task automatic drain;
      while (sample_queue.size() != 0 || req_tvalid || bin_results.size() != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   initial begin
      int len;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: one-sample frames at the sample extremes, zero vector, negative re
      set_bin(1, 0, 65536, 0);
      sample_queue = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
      drain();
      // zero length acts as one; the sine is nonzero, but one-sample frames leave the imaginary part zero
      set_bin(0, 131071, -65536, 65536);
      sample_queue = '{16'h7FFF, 16'h8000, 16'h1234};
      drain();
      set_bin(3, -131072, 0, -65536);
      sample_queue = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000};
      drain();
      // length change mid-frame: two samples taken, then length 2
      set_bin(5, 65536, 46341, 46341);
      sample_queue = '{16'h4000, 16'hC000};
      drain();
      csr_write(CSR_FRAME_LENGTH, 19'd2);
      sample_queue = '{16'h0100, 16'h0200, 16'h0300};
      drain();
      // resonator climbs close to its saturation bound over 400 full-scale samples
      set_bin(400, 131071, 65536, 0);
      for (int i = 0; i < 400; i++) sample_queue.push_back(16'h7FFF);
      drain();
      set_bin(4096, 131071, 65535, 1);
      sample_queue = '{16'h0001};
      drain();
      set_bin(4, 0, 65536, 0);

      // random frames, mostly short, under varying coefficients
      for (int ph = 0; ph < 8; ph++) begin
         quiet = (ph == 5);
         case ($urandom_range(9))
            0: len = $urandom_range(8191);
            1, 2: len = $urandom_range(64, 1);
            default: len = $urandom_range(16, 1);
         endcase
         set_bin(len, $urandom_range(262143) - 131072, $urandom_range(131072) - 65536,
                 $urandom_range(131072) - 65536);
         for (int i = 0; i < 100; i++) sample_queue.push_back(16'($urandom_range(65535)));
         drain();
      end
      quiet = 1'b0;

      if (errors == 0 && bin_results.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
src/gsbd_pkg.sv
src/gsbd_front.sv
src/gsbd_queue.sv
src/gsbd_back.sv
src/goertzel_single_bin_detector.sv
src/gsbd_checker.sv
tb/sv/tb.sv
